@@ src/cce_pkg.sv @@
// Shared constants and types for the configurable CRC engine.
// No dependencies; cce_fold and the top module refer to this package by scope.
`default_nettype none

package cce_pkg;

    // Variant codes held in the variant register
    localparam logic [2:0] VAR_CRC4      = 3'd0;
    localparam logic [2:0] VAR_CRC7      = 3'd1;
    localparam logic [2:0] VAR_CRC8      = 3'd2;
    localparam logic [2:0] VAR_CRC8_REFL = 3'd3;
    localparam logic [2:0] VAR_CRC16_REF = 3'd4;
    localparam logic [2:0] VAR_CRC16     = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_VARIANT = 2'd0;
    localparam logic [1:0] CFG_POLY    = 2'd1;
    localparam logic [1:0] CFG_INIT    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [2:0]  RST_VARIANT = VAR_CRC8;
    localparam logic [15:0] RST_POLY    = 16'h0007;
    localparam logic [15:0] RST_INIT    = 16'h0000;

    // Configuration seen by the fold datapath
    typedef struct packed {
        logic [2:0]  variant;
        logic [15:0] poly;
        logic [15:0] init;
    } t_crc_cfg;

endpackage

`default_nettype wire

@@ src/cce_if.sv @@
// Channel interfaces of the CRC engine: byte input, result output, config write.
// Depends on nothing; widths follow the block's field list.
`default_nettype none

interface cce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface cce_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] crc_value;
    logic        message_done;

    modport source (output valid, output crc_value, output message_done, input ready);
    modport sink   (input valid, input crc_value, input message_done, output ready);
endinterface

interface cce_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

@@ src/cce_fold.sv @@
// Combinational byte fold: reload from init, then eight unrolled CRC bit steps.
// Depends on cce_pkg for variant codes and the config struct.
`default_nettype none

module cce_fold (
    input  var cce_pkg::t_crc_cfg i_cfg,
    input  var logic [15:0]       i_remainder,
    input  var logic              i_at_start,
    input  var logic [7:0]        i_data,
    output var logic [15:0]       o_remainder,
    output var logic [15:0]       o_crc
);

    function automatic logic [7:0] rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = x[i];
        end
        return r;
    endfunction

    // Eight msb-first steps on an 8-bit register
    function automatic logic [7:0] msb_steps8(input logic [7:0] x, input logic [7:0] p);
        logic [7:0] r;
        r = x;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ p) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // Eight lsb-first steps on an 8-bit register
    function automatic logic [7:0] lsb_steps8(input logic [7:0] x, input logic [7:0] p);
        logic [7:0] r;
        r = x;
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ({1'b0, r[7:1]} ^ p) : {1'b0, r[7:1]};
        end
        return r;
    endfunction

    // Eight lsb-first steps on a 16-bit register
    function automatic logic [15:0] lsb_steps16(input logic [15:0] x, input logic [15:0] p);
        logic [15:0] r;
        r = x;
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ({1'b0, r[15:1]} ^ p) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // Eight msb-first steps on a 16-bit register
    function automatic logic [15:0] msb_steps16(input logic [15:0] x, input logic [15:0] p);
        logic [15:0] r;
        r = x;
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ p) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    logic [15:0] init_r;
    logic [15:0] start_r;
    logic [7:0]  r8;
    logic [7:0]  n8;

    // Reload value per variant, aligned the way the working register keeps it
    always_comb begin
        case (i_cfg.variant)
            cce_pkg::VAR_CRC4:      init_r = {8'h00, i_cfg.init[3:0], 4'h0};
            cce_pkg::VAR_CRC7:      init_r = {8'h00, i_cfg.init[6:0], 1'b0};
            cce_pkg::VAR_CRC8:      init_r = {8'h00, i_cfg.init[7:0]};
            cce_pkg::VAR_CRC8_REFL: init_r = {8'h00, rev8(i_cfg.init[7:0])};
            default:                init_r = i_cfg.init;
        endcase
    end

    assign start_r = i_at_start ? init_r : i_remainder;
    assign r8      = start_r[7:0] ^ i_data;

    // Fold the byte; codes above crc16 behave as crc16
    always_comb begin
        n8 = 8'h00;
        case (i_cfg.variant)
            cce_pkg::VAR_CRC4: begin
                n8          = msb_steps8(r8, {i_cfg.poly[3:0], 4'h0});
                o_remainder = {8'h00, n8};
                o_crc       = {12'h000, n8[7:4]};
            end
            cce_pkg::VAR_CRC7: begin
                n8          = msb_steps8(r8, {i_cfg.poly[6:0], 1'b0});
                o_remainder = {8'h00, n8};
                o_crc       = {9'h000, n8[7:1]};
            end
            cce_pkg::VAR_CRC8: begin
                n8          = msb_steps8(r8, i_cfg.poly[7:0]);
                o_remainder = {8'h00, n8};
                o_crc       = {8'h00, n8};
            end
            cce_pkg::VAR_CRC8_REFL: begin
                n8          = lsb_steps8(r8, rev8(i_cfg.poly[7:0]));
                o_remainder = {8'h00, n8};
                o_crc       = {8'h00, n8};
            end
            cce_pkg::VAR_CRC16_REF: begin
                o_remainder = lsb_steps16(start_r ^ {8'h00, i_data}, i_cfg.poly);
                o_crc       = o_remainder;
            end
            default: begin
                o_remainder = msb_steps16(start_r ^ {i_data, 8'h00}, i_cfg.poly);
                o_crc       = o_remainder;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/configurable_crc_engine_top.sv @@
// Configurable CRC engine: byte input stage, combinational fold, output register.
// A byte is registered in the input stage, then its result in the output register.
// Throughput: one byte per cycle while the output is not stalled; the unrolled 8-step fold sits between stages.
// Synchronous active-low reset: config to crc8/0x07/0, remainder 0, next byte reloads.
// Depends on cce_pkg, the cce_*_if interfaces and cce_fold.
`default_nettype none

module configurable_crc_engine_top (
    input  var logic   i_clk,
    input  var logic   i_rst_n,
    cce_in_if.sink     i_in,
    cce_out_if.source  o_out,
    cce_cfg_if.sink    i_cfg
);

    logic [2:0]  r_crc_variant;
    logic [15:0] r_generator_poly;
    logic [15:0] r_start_value;

    logic        r_s1_valid;
    logic [7:0]  r_s1_data;
    logic        r_s1_last;

    logic [15:0] r_remainder;
    logic        r_at_start;

    logic        r_out_valid;
    logic [15:0] r_out_crc;
    logic        r_out_done;

    logic [15:0]       n_remainder;
    logic [15:0]       n_crc;
    logic              s1_adv;
    logic              in_xfer;
    cce_pkg::t_crc_cfg fold_cfg;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_variant    <= cce_pkg::RST_VARIANT;
            r_generator_poly <= cce_pkg::RST_POLY;
            r_start_value    <= cce_pkg::RST_INIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                cce_pkg::CFG_VARIANT: r_crc_variant    <= i_cfg.write_data[2:0];
                cce_pkg::CFG_POLY:    r_generator_poly <= i_cfg.write_data;
                cce_pkg::CFG_INIT:    r_start_value    <= i_cfg.write_data;
                default: ;
            endcase
        end
    end

    // Handshake: input stage advances whenever the output register is free or drains
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= i_in.data_byte;
            r_s1_last <= i_in.end_of_message;
        end
    end

    // Fold datapath
    assign fold_cfg = '{variant: r_crc_variant, poly: r_generator_poly, init: r_start_value};

    cce_fold u_fold (
        .i_cfg       (fold_cfg),
        .i_remainder (r_remainder),
        .i_at_start  (r_at_start),
        .i_data      (r_s1_data),
        .o_remainder (n_remainder),
        .o_crc       (n_crc)
    );

    // Running state commits when the byte moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remainder <= 16'h0000;
            r_at_start  <= 1'b1;
        end else if (s1_adv) begin
            r_remainder <= n_remainder;
            r_at_start  <= r_s1_last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_crc  <= n_crc;
            r_out_done <= r_s1_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.crc_value    = r_out_crc;
    assign o_out.message_done = r_out_done;

    // Checks
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("output register not loaded after stage advance");

    a_reload_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> (r_at_start == $past(r_s1_last)))
        else $error("reload flag does not follow last-byte marker");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_crc)))
        else $error("stalled result overwritten");

    a_narrow_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (r_crc_variant == cce_pkg::VAR_CRC4 || r_crc_variant == cce_pkg::VAR_CRC8))
        |=> (r_remainder[15:8] == 8'h00))
        else $error("narrow variant left upper remainder bits set");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("empty input stage refuses a transfer");

endmodule

`default_nettype wire
